@@ src/mbps_pkg.sv @@
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types, constants and register codes for the masked byte scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int LEN_W       = 5;
    localparam int ADDR_W      = 64;
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 6;

    // register codes, taken from paddr[5:3]
    typedef enum logic [2:0] {
        REG_PAT_LOW  = 3'd0,
        REG_PAT_HIGH = 3'd1,
        REG_WILD     = 3'd2,
        REG_LEN      = 3'd3,
        REG_BASE     = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_scan_in;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } t_scan_out;

    typedef struct packed {
        logic [63:0]            pattern_bytes_high;
        logic [63:0]            pattern_bytes_low;
        logic [PATTERN_MAX-1:0] wildcard_mask;
        logic [LEN_W-1:0]       pattern_length;
        logic [ADDR_W-1:0]      base_address;
    } t_cfg;

    typedef struct packed {
        logic advance;
        logic clear;
    } t_cell_ctl;

    // pattern length clipped to the cell count
    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (len > LEN_W'(PATTERN_MAX)) begin
            res = LEN_W'(PATTERN_MAX);
        end
        return res;
    endfunction

endpackage

@@ src/mbps_cell.sv @@
// ----------------------------------------------------------------------------
// mbps_cell
// One scan cell: holds the flag "pattern bytes 0..k matched ending at the
// newest word" and passes it to the next cell.
// ----------------------------------------------------------------------------
module mbps_cell
    import mbps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_prev_flag,
    input  logic [7:0] i_data,
    input  logic [7:0] i_pat,
    input  logic      i_wild,
    output logic      o_flag_next,
    output logic      o_flag
);

    logic r_flag;
    logic n_flag;

    assign o_flag_next = i_prev_flag & (i_wild | (i_data == i_pat));

    always_comb begin
        n_flag = r_flag;
        if (i_ctl.advance) begin
            n_flag = i_ctl.clear ? 1'b0 : o_flag_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else begin
            r_flag <= n_flag;
        end
    end

    assign o_flag = r_flag;

endmodule

@@ src/mbps_regs.sv @@
// ----------------------------------------------------------------------------
// mbps_regs
// APB-style configuration registers of the scanner.
// ----------------------------------------------------------------------------
module mbps_regs
    import mbps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[5:3]);
    assign w_wr   = psel & penable & pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_PAT_LOW:  n_cfg.pattern_bytes_low  = pwdata;
                REG_PAT_HIGH: n_cfg.pattern_bytes_high = pwdata;
                REG_WILD:     n_cfg.wildcard_mask      = pwdata[PATTERN_MAX-1:0];
                REG_LEN:      n_cfg.pattern_length     = pwdata[LEN_W-1:0];
                REG_BASE:     n_cfg.base_address       = pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PAT_LOW:  prdata = r_cfg.pattern_bytes_low;
            REG_PAT_HIGH: prdata = r_cfg.pattern_bytes_high;
            REG_WILD:     prdata = APB_DATA_W'(r_cfg.wildcard_mask);
            REG_LEN:      prdata = APB_DATA_W'(r_cfg.pattern_length);
            REG_BASE:     prdata = r_cfg.base_address;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/masked_byte_pattern_scanner.sv @@
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Wildcard byte signature scan over a streamed memory range.
// ----------------------------------------------------------------------------
// Takes one byte word per cycle, back to back, with no gaps needed. A row of
// 16 cells, one per pattern byte, carries partial-match flags along the chain
// per word taken, so every window position is tested; the leftmost match wins.
// On the word marked last the report (found, match address = base + offset)
// appears in the output register on the next cycle and the scan state clears
// in the same edge, so the next range can start at once. Non-last words are
// taken even while a report waits; a last word is held off only while the
// previous report is still stalled. A zero pattern length never matches;
// lengths above 16 act as 16.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner
    import mbps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_scan_in              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_scan_out             o_out_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg w_cfg;

    mbps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic                  w_acc;
    logic                  w_last_acc;
    t_cell_ctl             w_ctl;
    logic [PATTERN_MAX-1:0] w_flag;
    logic [PATTERN_MAX-1:0] w_flag_next;
    logic [127:0]          w_pat_all;
    logic [LEN_W-1:0]      w_len;
    logic [IDX_W-1:0]      w_lenm1;
    logic                  w_hit;
    logic [ADDR_W-1:0]     w_cand;

    logic                  r_seen;
    logic [ADDR_W-1:0]     r_first;
    logic [ADDR_W-1:0]     r_idx;
    logic                  r_out_valid;
    t_scan_out             r_out_word;
    logic                  n_seen;
    logic [ADDR_W-1:0]     n_first;
    logic [ADDR_W-1:0]     n_idx;
    logic                  n_out_valid;
    t_scan_out             n_out_word;

    // only a last word needs the output register
    assign o_in_stall = r_out_valid & i_out_stall & i_in_word.last_byte;
    assign w_acc      = i_in_valid & ~o_in_stall;
    assign w_last_acc = w_acc & i_in_word.last_byte;

    assign w_ctl.advance = w_acc;
    assign w_ctl.clear   = i_in_word.last_byte;

    assign w_pat_all = {w_cfg.pattern_bytes_high, w_cfg.pattern_bytes_low};

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
            logic w_prev;
            if (k == 0) begin : g_head
                assign w_prev = 1'b1;
            end else begin : g_link
                assign w_prev = w_flag[k-1];
            end
            mbps_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_prev_flag (w_prev),
                .i_data      (i_in_word.data_byte),
                .i_pat       (w_pat_all[8*k +: 8]),
                .i_wild      (w_cfg.wildcard_mask[k]),
                .o_flag_next (w_flag_next[k]),
                .o_flag      (w_flag[k])
            );
        end
    endgenerate

    assign w_len   = sat_len(w_cfg.pattern_length);
    assign w_lenm1 = IDX_W'(w_len - LEN_W'(1));
    assign w_hit   = (w_len != '0) & ~r_seen & w_flag_next[w_lenm1];
    assign w_cand  = w_cfg.base_address + r_idx - ADDR_W'(w_lenm1);

    always_comb begin
        n_seen      = r_seen;
        n_first     = r_first;
        n_idx       = r_idx;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_word  = r_out_word;
        if (w_acc) begin
            if (w_hit) begin
                n_seen  = 1'b1;
                n_first = w_cand;
            end
            n_idx = r_idx + ADDR_W'(1);
            if (i_in_word.last_byte) begin
                n_out_valid              = 1'b1;
                n_out_word.found         = r_seen | w_hit;
                n_out_word.match_address = r_seen ? r_first : (w_hit ? w_cand : '0);
                n_seen                   = 1'b0;
                n_first                  = '0;
                n_idx                    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_first     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seen      <= n_seen;
            r_first     <= n_first;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_report_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_acc |=> r_out_valid)
        else $error("no report after last word");

    a_scan_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_acc |=> (!r_seen && r_idx == '0 && w_flag == '0))
        else $error("scan state not cleared after last word");

    a_no_found_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_word.found) |-> (r_out_word.match_address == '0))
        else $error("address set on a report without a match");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid)
        else $error("input stalled with empty output register");

endmodule

@@ sim/tb_masked_byte_pattern_scanner.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_masked_byte_pattern_scanner
// Self-checking bench for the wildcard byte signature scanner.
// ----------------------------------------------------------------------------
// Byte words stream in with random gaps, and the report side is stalled at
// random. A scoreboard keeps its own copy of the pattern registers and of the
// sliding window and predicts one report per range. Each report that the
// scanner hands out is compared against the oldest prediction. A short
// directed part comes first: zero length, a wildcard byte, overlapping
// candidates, too few bytes, address wrap and extreme byte values. After that,
// random phases each program every register and then send ranges. Most of
// these ranges hold planted copies of the pattern.
// ----------------------------------------------------------------------------
import mbps_pkg::*;

class scan_report_board;
    t_cfg        cfg;
    logic [7:0]  window[PATTERN_MAX];
    logic [63:0] byte_count;
    logic        hit_seen;
    logic [63:0] hit_offset;
    t_scan_out   reports_due[$];
    int          errors;

    function new();
        cfg    = '0;
        errors = 0;
        clear_scan();
    endfunction

    function void clear_scan();
        for (int i = 0; i < PATTERN_MAX; i++) begin
            window[i] = '0;
        end
        byte_count = '0;
        hit_seen   = 1'b0;
        hit_offset = '0;
    endfunction

    function void write_reg(t_reg_idx idx, logic [63:0] value);
        case (idx)
            REG_PAT_LOW: begin
                cfg.pattern_bytes_low = value;
            end
            REG_PAT_HIGH: begin
                cfg.pattern_bytes_high = value;
            end
            REG_WILD: begin
                cfg.wildcard_mask = value[PATTERN_MAX-1:0];
            end
            REG_LEN: begin
                cfg.pattern_length = value[LEN_W-1:0];
            end
            REG_BASE: begin
                cfg.base_address = value;
            end
            default: begin
            end
        endcase
    endfunction

    function void take_byte(t_scan_in w);
        int         len;
        logic       hit;
        logic [7:0] want;
        t_scan_out  rep;
        len = int'(cfg.pattern_length);
        if (len > PATTERN_MAX) begin
            len = PATTERN_MAX;
        end
        for (int i = PATTERN_MAX - 1; i > 0; i--) begin
            window[i] = window[i-1];
        end
        window[0] = w.data_byte;
        // window[0] is the newest byte, so pattern byte k sits at len-1-k
        if (len > 0 && !hit_seen && byte_count >= 64'(len - 1)) begin
            hit = 1'b1;
            for (int k = 0; k < len; k++) begin
                want = (k < 8) ? cfg.pattern_bytes_low[8*k +: 8]
                               : cfg.pattern_bytes_high[8*(k-8) +: 8];
                if (!cfg.wildcard_mask[k] && window[len-1-k] !== want) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                hit_seen   = 1'b1;
                hit_offset = byte_count - 64'(len - 1);
            end
        end
        byte_count = byte_count + 64'd1;
        if (w.last_byte) begin
            rep.found         = hit_seen;
            rep.match_address = hit_seen ? cfg.base_address + hit_offset : '0;
            reports_due = {reports_due, rep};
            clear_scan();
        end
    endfunction

    function void check_report(t_scan_out got);
        t_scan_out want;
        if (reports_due.size() == 0) begin
            $display("%0t: report with none due, got found=%0b addr=%h",
                     $time, got.found, got.match_address);
            errors++;
            return;
        end
        want = reports_due.pop_front();
        if (got.found !== want.found) begin
            $display("%0t: found mismatch, expected %0b, got %0b",
                     $time, want.found, got.found);
            errors++;
        end
        if (got.match_address !== want.match_address) begin
            $display("%0t: match_address mismatch, expected %h, got %h",
                     $time, want.match_address, got.match_address);
            errors++;
        end
    endfunction

    function int pending();
        return reports_due.size();
    endfunction
endclass

module tb_masked_byte_pattern_scanner;
    import mbps_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int ITEM_TARGET = 2000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_scan_in              i_in_word   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_scan_out             o_out_word;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    scan_report_board board;
    logic [7:0]       scan_buf[$];
    int               items_sent  = 0;
    int               stall_left  = 0;
    int               idle_cycles = 0;
    bit               no_gaps     = 1'b0;
    bit               no_stalls   = 1'b0;

    masked_byte_pattern_scanner u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // mostly none, often a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            if (!no_stalls && $urandom_range(0, 2) == 0) begin
                stall_left = 1 + pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_report(o_out_word);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || psel) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_masked_byte_pattern_scanner: done, errors");
                $finish;
            end
        end
    end

    task automatic apb_write(input t_reg_idx idx, input logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.write_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_word(input logic [7:0] data, input logic last);
        int unsigned gap;
        t_scan_in    w;
        w   = t_scan_in'{data_byte: data, last_byte: last};
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.take_byte(w);
        items_sent++;
    endtask

    task automatic send_scan();
        foreach (scan_buf[i]) begin
            send_word(scan_buf[i], i == scan_buf.size() - 1);
        end
    endtask

    // hold the sender off until every report is in, then let the pipe empty
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic random_phase();
        logic [7:0]  pat[PATTERN_MAX];
        logic [7:0]  alpha[2];
        logic [63:0] pat_low;
        logic [63:0] pat_high;
        logic [15:0] wild;
        logic [63:0] base;
        int          len;
        int          eff;
        int          size;
        int          pos;
        int          r;
        bit          narrow;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            len = 0;
        end else if (r == 1) begin
            len = 16;
        end else if (r == 2) begin
            len = $urandom_range(17, 31);
        end else if (r < 6) begin
            len = $urandom_range(9, 15);
        end else begin
            len = $urandom_range(1, 8);
        end
        eff = (len > PATTERN_MAX) ? PATTERN_MAX : len;
        // a two-letter alphabet gives many partial and overlapping candidates
        narrow   = ($urandom_range(0, 1) == 1);
        alpha[0] = 8'($urandom);
        alpha[1] = 8'($urandom);
        for (int k = 0; k < PATTERN_MAX; k++) begin
            pat[k] = narrow ? alpha[$urandom_range(0, 1)] : 8'($urandom);
        end
        for (int k = 0; k < 8; k++) begin
            pat_low[8*k +: 8]  = pat[k];
            pat_high[8*k +: 8] = pat[k+8];
        end
        r = $urandom_range(0, 9);
        if (r == 0) begin
            wild = 16'h0000;
        end else if (r == 1) begin
            wild = 16'hFFFF;
        end else begin
            wild = 16'($urandom) & 16'($urandom);
        end
        r = $urandom_range(0, 9);
        if (r == 0) begin
            base = '0;
        end else if (r == 1) begin
            base = '1;
        end else if (r == 2) begin
            base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 200));
        end else begin
            base = {$urandom, $urandom};
        end
        no_gaps   = ($urandom_range(0, 3) == 0);
        no_stalls = ($urandom_range(0, 3) == 0);

        apb_write(REG_PAT_LOW, pat_low);
        apb_write(REG_PAT_HIGH, pat_high);
        apb_write(REG_WILD, 64'(wild));
        apb_write(REG_LEN, 64'(len));
        apb_write(REG_BASE, base);

        repeat ($urandom_range(2, 8)) begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120)
                                                : $urandom_range(1, 40);
            scan_buf.delete();
            repeat (size) begin
                scan_buf = {scan_buf, (narrow && $urandom_range(0, 9) < 7)
                                      ? alpha[$urandom_range(0, 1)] : 8'($urandom)};
            end
            // plant one or two copies; wildcard slots keep their random byte
            if (eff > 0 && eff <= size && $urandom_range(0, 99) < 65) begin
                repeat ($urandom_range(1, 2)) begin
                    pos = $urandom_range(0, size - eff);
                    for (int k = 0; k < eff; k++) begin
                        if (!wild[k]) begin
                            scan_buf[pos+k] = pat[k];
                        end
                    end
                end
            end
            send_scan();
        end
        settle();
    endtask

    initial begin
        board = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset: zero length never matches
        scan_buf = '{8'h00, 8'hFF};
        send_scan();
        settle();

        // pattern aa ?? cc dd with the base just below the wrap point
        apb_write(REG_PAT_LOW, 64'h0000_0000_DDCC_55AA);
        apb_write(REG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        apb_write(REG_WILD, 64'h0000_0000_0000_0002);
        apb_write(REG_LEN, 64'd4);
        apb_write(REG_BASE, 64'hFFFF_FFFF_FFFF_FFFE);
        // candidate at offset 2 fails, overlapping one at offset 3 hits
        scan_buf = '{8'h00, 8'h00, 8'hAA, 8'hAA, 8'h00, 8'hCC, 8'hDD};
        send_scan();
        // range shorter than the pattern
        scan_buf = '{8'hAA, 8'h00};
        send_scan();
        // match completes on the last word itself
        scan_buf = '{8'hAA, 8'h12, 8'hCC, 8'hDD};
        send_scan();
        settle();

        apb_write(REG_PAT_LOW, 64'h0000_0000_0000_00FF);
        apb_write(REG_WILD, 64'h0);
        apb_write(REG_LEN, 64'd1);
        apb_write(REG_BASE, 64'h0);
        scan_buf = '{8'hFF};
        send_scan();
        scan_buf = '{8'h00, 8'h7F, 8'hFF};
        send_scan();
        settle();

        while (items_sent < ITEM_TARGET) begin
            random_phase();
        end
        settle();

        if (board.errors == 0 && board.pending() == 0) begin
            $display("tb_masked_byte_pattern_scanner: done, clean");
        end else begin
            $display("tb_masked_byte_pattern_scanner: done, errors");
        end
        $finish;
    end

endmodule
